FILE: src/strl_pkg.sv
// ----------------------------------------------------------------------------
// strl_pkg
// Shared types and constants of the spike trace linear readout: item
// layouts, operation codes, and the command and status groups between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package strl_pkg;

  // Default sizes of the stores.
  localparam int NUM_CHANNELS_DEF = 64;
  localparam int NUM_OUTPUTS_DEF  = 8;
  localparam int TIME_SLOTS_DEF   = 16;

  // A tick never produces more commands than this.
  localparam int MAX_RESULTS = 8;

  // Decay factor after reset, unsigned Q0.16.
  localparam logic [15:0] DECAY_RESET = 16'hFFFF;

  // Operation codes of an input item.
  localparam logic [1:0] OP_SPIKE    = 2'd0;
  localparam logic [1:0] OP_TICK     = 2'd1;
  localparam logic [1:0] OP_WR_WEIGHT = 2'd2;
  localparam logic [1:0] OP_WR_INCR  = 2'd3;

  typedef struct packed {
    logic [1:0]          operation;
    logic [5:0]          channel;
    logic [2:0]          out_select;
    logic [3:0]          time_slot;
    logic signed [31:0]  value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]          out_index;
    logic signed [31:0]  command;
    logic                last;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;     // an input item transfers this cycle
    logic spike_wr;   // write back the spike sum
    logic clr_step;   // one step of the clearing pass
    logic dec_issue;  // read one trace for decay
    logic dot_issue;  // read one weight and trace pair
    logic load_out;   // load a finished command into the output register
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic clr_last;   // clearing pass is at its final entry
    logic ch_last;    // channel counter is at the final channel
    logic dot_busy;   // multiply-accumulate pipeline still holds data
    logic out_free;   // output register can take a new command
    logic row_last;   // current row is the final row of the tick
  } ctrl_sts_t;

endpackage

FILE: src/strl_stream_if.sv
// ----------------------------------------------------------------------------
// strl_stream_if
// Valid/ready channel carrying one payload of type T per transfer.
// ----------------------------------------------------------------------------
interface strl_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: src/strl_ram.sv
// ----------------------------------------------------------------------------
// strl_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module strl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/strl_ctrl.sv
// ----------------------------------------------------------------------------
// strl_ctrl
// Sequencer of the readout: clearing pass after reset, item dispatch,
// spike write-back, trace decay sweep and the row-by-row dot products.
// ----------------------------------------------------------------------------
module strl_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [1:0]           in_op_i,
  output logic                 in_ready_o,
  input  strl_pkg::ctrl_sts_t  sts_i,
  output strl_pkg::ctrl_cmd_t  cmd_o
);
  import strl_pkg::*;

  localparam logic [2:0] S_CLEAR   = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_SPIKE   = 3'd2;
  localparam logic [2:0] S_DECAY   = 3'd3;
  localparam logic [2:0] S_DEC_END = 3'd4;
  localparam logic [2:0] S_DOT     = 3'd5;
  localparam logic [2:0] S_DOT_END = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (in_op_i == OP_SPIKE) begin
            state_d = S_SPIKE;
          end else if (in_op_i == OP_TICK) begin
            state_d = S_DECAY;
          end
        end
      end
      S_SPIKE: begin
        cmd_o.spike_wr = 1'b1;
        state_d        = S_IDLE;
      end
      S_DECAY: begin
        cmd_o.dec_issue = 1'b1;
        if (sts_i.ch_last) begin
          state_d = S_DEC_END;
        end
      end
      // The final decayed trace is written back during this cycle.
      S_DEC_END: begin
        state_d = S_DOT;
      end
      S_DOT: begin
        cmd_o.dot_issue = 1'b1;
        if (sts_i.ch_last) begin
          state_d = S_DOT_END;
        end
      end
      S_DOT_END: begin
        if (!sts_i.dot_busy && sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = sts_i.row_last ? S_IDLE : S_DOT;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // A spike transfer is always followed by its write-back.
  a_spike_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.accept && in_op_i == OP_SPIKE) |=> cmd_o.spike_wr)
    else $error("spike transfer not followed by write-back");

  // The final command of a tick returns the sequencer to idle.
  a_tick_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load_out && sts_i.row_last) |=> in_ready_o)
    else $error("sequencer not idle after final command");

  // A command is only loaded when the previous state is S_DOT or S_DOT_END.
  a_load_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> ($past(state_q) == S_DOT_END || $past(state_q) == S_DOT))
    else $error("command loaded outside the dot sequence");

endmodule

FILE: src/strl_dp.sv
// ----------------------------------------------------------------------------
// strl_dp
// Datapath of the readout: trace, weight and increment memories, the
// decay multiplier, the multiply-accumulate pipeline and the output register.
// ----------------------------------------------------------------------------
module strl_dp #(
  parameter int NUM_CHANNELS = strl_pkg::NUM_CHANNELS_DEF,
  parameter int NUM_OUTPUTS  = strl_pkg::NUM_OUTPUTS_DEF,
  parameter int TIME_SLOTS   = strl_pkg::TIME_SLOTS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  strl_pkg::ctrl_cmd_t  cmd_i,
  output strl_pkg::ctrl_sts_t  sts_o,
  input  strl_pkg::in_item_t   in_item_i,
  input  logic                 cfg_we_i,
  input  logic [15:0]          cfg_wdata_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output strl_pkg::out_item_t  out_item_o
);
  import strl_pkg::*;

  localparam int CHW       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int NROWS     = (NUM_OUTPUTS < MAX_RESULTS) ? NUM_OUTPUTS : MAX_RESULTS;
  localparam int RW        = (NROWS > 1) ? $clog2(NROWS) : 1;
  localparam int WDEPTH    = NUM_OUTPUTS * NUM_CHANNELS;
  localparam int WAW       = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int TSW       = (TIME_SLOTS > 1) ? $clog2(TIME_SLOTS) : 1;
  localparam int CLEAR_LEN = (WDEPTH > TIME_SLOTS) ? WDEPTH : TIME_SLOTS;
  localparam int CLRW      = (CLEAR_LEN > 1) ? $clog2(CLEAR_LEN) : 1;
  localparam int ACCW      = 64 + CHW;

  // Configuration.
  logic [15:0] decay_q;

  // Counters.
  logic [CLRW-1:0] clr_q;
  logic [CHW-1:0]  ch_q;
  logic [WAW-1:0]  wa_q;
  logic [RW-1:0]   row_q;

  // Input decode.
  logic        in_ch_ok, in_row_ok, in_slot_ok;
  logic [31:0] in_ch_ext, in_slot_ext, in_waddr_ext;
  logic        acc_tick, acc_spike, acc_wr_w, acc_wr_i;

  // Memory ports.
  logic            tr_we, w_we, inc_we;
  logic [CHW-1:0]  tr_waddr, tr_raddr;
  logic [31:0]     tr_wdata, tr_rdata;
  logic [WAW-1:0]  w_waddr;
  logic [31:0]     w_wdata, w_rdata;
  logic [TSW-1:0]  inc_waddr, inc_raddr;
  logic [31:0]     inc_wdata, inc_rdata;

  // Spike path.
  logic [CHW-1:0] spk_a_q;
  logic           spk_ok_q;
  logic [32:0]    spk_sum;
  logic [31:0]    spk_sat;

  // Decay path.
  logic                dec_v1_q;
  logic [CHW-1:0]      dec_a1_q;
  logic signed [48:0]  dec_prod;
  logic signed [48:0]  dec_rnd;

  // Multiply-accumulate path.
  logic                  dot_v1_q, dot_v2_q;
  logic                  first1_q, first2_q;
  logic signed [63:0]    prod_q;
  logic signed [ACCW-1:0] acc_q, acc_d, prod_ext, acc_rnd;
  logic [ACCW-48:0]      acc_top;
  logic [31:0]           cmd_sat;

  // Output register.
  logic      out_valid_q;
  out_item_t out_item_q;

  // --------------------------------------------------------------------------
  // Input decode
  // --------------------------------------------------------------------------
  assign in_ch_ext    = 32'(in_item_i.channel);
  assign in_slot_ext  = 32'(in_item_i.time_slot);
  assign in_waddr_ext = 32'(in_item_i.out_select) * 32'(NUM_CHANNELS) + in_ch_ext;
  assign in_ch_ok     = in_ch_ext < 32'(NUM_CHANNELS);
  assign in_row_ok    = 32'(in_item_i.out_select) < 32'(NUM_OUTPUTS);
  assign in_slot_ok   = in_slot_ext < 32'(TIME_SLOTS);

  assign acc_tick  = cmd_i.accept && (in_item_i.operation == OP_TICK);
  assign acc_spike = cmd_i.accept && (in_item_i.operation == OP_SPIKE);
  assign acc_wr_w  = cmd_i.accept && (in_item_i.operation == OP_WR_WEIGHT);
  assign acc_wr_i  = cmd_i.accept && (in_item_i.operation == OP_WR_INCR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_q <= DECAY_RESET;
    end else if (cfg_we_i) begin
      decay_q <= cfg_wdata_i;
    end
  end

  // --------------------------------------------------------------------------
  // Memories
  // --------------------------------------------------------------------------
  always_comb begin
    tr_we    = 1'b0;
    tr_waddr = dec_a1_q;
    tr_wdata = dec_rnd[47:16];
    if (cmd_i.clr_step) begin
      tr_we    = 32'(clr_q) < 32'(NUM_CHANNELS);
      tr_waddr = clr_q[CHW-1:0];
      tr_wdata = '0;
    end else if (cmd_i.spike_wr) begin
      tr_we    = spk_ok_q;
      tr_waddr = spk_a_q;
      tr_wdata = spk_sat;
    end else if (dec_v1_q) begin
      tr_we = 1'b1;
    end
  end

  // A spike reads its trace at the transfer; sweeps read at the counter.
  assign tr_raddr = cmd_i.accept ? in_ch_ext[CHW-1:0] : ch_q;

  always_comb begin
    if (cmd_i.clr_step) begin
      w_we    = 32'(clr_q) < 32'(WDEPTH);
      w_waddr = clr_q[WAW-1:0];
      w_wdata = '0;
      inc_we    = 32'(clr_q) < 32'(TIME_SLOTS);
      inc_waddr = clr_q[TSW-1:0];
      inc_wdata = '0;
    end else begin
      w_we    = acc_wr_w && in_ch_ok && in_row_ok;
      w_waddr = in_waddr_ext[WAW-1:0];
      w_wdata = in_item_i.value;
      inc_we    = acc_wr_i && in_slot_ok;
      inc_waddr = in_slot_ext[TSW-1:0];
      inc_wdata = in_item_i.value;
    end
  end

  assign inc_raddr = in_slot_ext[TSW-1:0];

  strl_ram #(.WIDTH(32), .DEPTH(NUM_CHANNELS)) u_trace_ram (
    .clk_i   (clk_i),
    .we_i    (tr_we),
    .waddr_i (tr_waddr),
    .wdata_i (tr_wdata),
    .raddr_i (tr_raddr),
    .rdata_o (tr_rdata)
  );

  strl_ram #(.WIDTH(32), .DEPTH(WDEPTH)) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (w_waddr),
    .wdata_i (w_wdata),
    .raddr_i (wa_q),
    .rdata_o (w_rdata)
  );

  strl_ram #(.WIDTH(32), .DEPTH(TIME_SLOTS)) u_incr_ram (
    .clk_i   (clk_i),
    .we_i    (inc_we),
    .waddr_i (inc_waddr),
    .wdata_i (inc_wdata),
    .raddr_i (inc_raddr),
    .rdata_o (inc_rdata)
  );

  // --------------------------------------------------------------------------
  // Counters
  // --------------------------------------------------------------------------
  assign sts_o.clr_last = clr_q == CLRW'(CLEAR_LEN - 1);
  assign sts_o.ch_last  = ch_q == CHW'(NUM_CHANNELS - 1);
  assign sts_o.row_last = row_q == RW'(NROWS - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
      ch_q  <= '0;
      wa_q  <= '0;
      row_q <= '0;
    end else begin
      if (cmd_i.clr_step && !sts_o.clr_last) begin
        clr_q <= clr_q + 1'b1;
      end
      if (acc_tick) begin
        ch_q <= '0;
      end else if (cmd_i.dec_issue || cmd_i.dot_issue) begin
        ch_q <= sts_o.ch_last ? '0 : ch_q + 1'b1;
      end
      if (acc_tick) begin
        wa_q <= '0;
      end else if (cmd_i.dot_issue) begin
        wa_q <= wa_q + 1'b1;
      end
      if (acc_tick) begin
        row_q <= '0;
      end else if (cmd_i.load_out && !sts_o.row_last) begin
        row_q <= row_q + 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Spike: saturating add of the increment to the trace
  // --------------------------------------------------------------------------
  assign spk_sum = {tr_rdata[31], tr_rdata} + {inc_rdata[31], inc_rdata};

  always_comb begin
    if (spk_sum[32] != spk_sum[31]) begin
      spk_sat = spk_sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      spk_sat = spk_sum[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spk_ok_q <= 1'b0;
    end else if (cmd_i.accept) begin
      spk_ok_q <= acc_spike && in_ch_ok && in_slot_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      spk_a_q <= in_ch_ext[CHW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Decay: trace times factor, rounded half up to Q16.16
  // --------------------------------------------------------------------------
  assign dec_prod = $signed(tr_rdata) * $signed({1'b0, decay_q});
  assign dec_rnd  = dec_prod + 49'sd32768;

  // --------------------------------------------------------------------------
  // Dot product: read, multiply, accumulate
  // --------------------------------------------------------------------------
  assign prod_ext = {{(ACCW - 64){prod_q[63]}}, prod_q};
  assign acc_d    = first2_q ? prod_ext : acc_q + prod_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_v1_q <= 1'b0;
      dot_v1_q <= 1'b0;
      dot_v2_q <= 1'b0;
    end else begin
      dec_v1_q <= cmd_i.dec_issue;
      dot_v1_q <= cmd_i.dot_issue;
      dot_v2_q <= dot_v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dec_a1_q <= ch_q;
    first1_q <= ch_q == '0;
    first2_q <= first1_q;
    if (dot_v1_q) begin
      prod_q <= $signed(tr_rdata) * $signed(w_rdata);
    end
    if (dot_v2_q) begin
      acc_q <= acc_d;
    end
  end

  assign sts_o.dot_busy = dot_v1_q || dot_v2_q;

  // Round half up at bit 15, then saturate the Q16.16 result to 32 bits.
  assign acc_rnd = acc_q + ACCW'(32768);
  assign acc_top = acc_rnd[ACCW-1:47];

  always_comb begin
    if ((&acc_top) || !(|acc_top)) begin
      cmd_sat = acc_rnd[47:16];
    end else begin
      cmd_sat = acc_rnd[ACCW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_item_q.out_index <= 3'(row_q);
      out_item_q.command   <= cmd_sat;
      out_item_q.last      <= sts_o.row_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Only one source writes the trace memory in any cycle.
  a_tr_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_i.clr_step, cmd_i.spike_wr, dec_v1_q}))
    else $error("trace memory written by more than one source");

  // The dot sweep never reads traces while a decay write is pending.
  a_no_dot_during_decay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.dot_issue |-> !dec_v1_q)
    else $error("dot read overlaps decay write-back");

  // A pending command is never overwritten before its transfer.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten");

endmodule

FILE: src/spike_trace_linear_readout.sv
// A spike item reads its trace, then writes back the saturated sum; weight and
// increment writes complete at their transfer. A tick runs a decay sweep over
// all channels, then one dot sweep per row for R = min(NUM_OUTPUTS, 8) rows,
// reading one trace per cycle in the decay sweep and one weight/trace pair per
// cycle in the dot sweep. After reset, clearing max(NUM_OUTPUTS*NUM_CHANNELS,
// TIME_SLOTS) entries zeroes all memories; no input transfers until it is done.
// ----------------------------------------------------------------------------
// spike_trace_linear_readout
// Spike-to-command decoder: per-channel exponential traces, decayed on each
// tick and read out through a weight matrix as saturated Q16.16 commands.
// ----------------------------------------------------------------------------
module spike_trace_linear_readout #(
  parameter int NUM_CHANNELS = strl_pkg::NUM_CHANNELS_DEF,
  parameter int NUM_OUTPUTS  = strl_pkg::NUM_OUTPUTS_DEF,
  parameter int TIME_SLOTS   = strl_pkg::TIME_SLOTS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [15:0]   cfg_wdata_i,
  strl_stream_if.sink   in_i,
  strl_stream_if.source out_o
);
  import strl_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;
  logic      in_ready;
  logic      out_valid;
  out_item_t out_item;

  strl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_op_i    (in_i.payload.operation),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  strl_dp #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .NUM_OUTPUTS  (NUM_OUTPUTS),
    .TIME_SLOTS   (TIME_SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_item_i   (in_i.payload),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_valid),
    .out_item_o  (out_item)
  );

  assign in_i.ready    = in_ready;
  assign out_o.valid   = out_valid;
  assign out_o.payload = out_item;

endmodule
